// ===== sv/fifo_uart_transmitter_defines.svh =====
// Assertion helpers for the transmitter modules; fut_back includes them.
`ifndef FIFO_UART_TRANSMITTER_DEFINES_SVH
`define FIFO_UART_TRANSMITTER_DEFINES_SVH

// Checked on every edge outside reset.
`define FUT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every edge that follows one on which a given condition holds.
`define FUT_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond) |=> (prop)) else $error(msg);

`endif

// ===== sv/fut_pkg.sv =====
package fut_pkg;

	localparam int FIFO_DEPTH_DEF  = 512;
	localparam int FRAME_TICKS_DEF = 15;

	// request codes
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// positions within a frame
	localparam logic [3:0] POS_START     = 4'd0;
	localparam logic [3:0] POS_LAST_DATA = 4'd8;
	localparam logic [3:0] POS_LAST_STOP = 4'd10;

	localparam int COUNT_W = 10;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
	} fut_in_t;

	typedef struct packed {
		logic               tx_line;
		logic [COUNT_W-1:0] fifo_count;
		logic               write_dropped;
		logic               frame_done;
	} fut_out_t;

	// classified item handed from front to back
	typedef struct packed {
		logic       is_tick;
		logic [7:0] data;
	} fut_item_t;

endpackage

// ===== sv/fut_front.sv =====
module fut_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  fut_pkg::fut_in_t  req,
	output logic              item_valid,
	input  logic              item_ready,
	output fut_pkg::fut_item_t item
);

	fut_pkg::fut_item_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	fut_pkg::fut_item_t decoded;
	logic       push;
	logic       pop;

	always_comb begin
		decoded.data = req.data_byte;
		unique case (req.req_type)
			fut_pkg::REQ_TICK: decoded.is_tick = 1'b1;
			fut_pkg::REQ_PUSH: decoded.is_tick = 1'b0;
			default:           decoded.is_tick = 1'b0;
		endcase
	end

	assign req_ready  = (cnt_q != 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = slot_q[rd_ptr_q];
	assign push       = req_valid && req_ready;
	assign pop        = item_valid && item_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/fut_back.sv =====
`include "fifo_uart_transmitter_defines.svh"

module fut_back #(
	parameter int FIFO_DEPTH  = fut_pkg::FIFO_DEPTH_DEF,
	parameter int FRAME_TICKS = fut_pkg::FRAME_TICKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  fut_pkg::fut_item_t item,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output fut_pkg::fut_out_t  rsp
);

	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	logic [7:0]    mem [FIFO_DEPTH];
	logic [7:0]    send_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [3:0]    pos_q;
	logic          line_q;
	logic          rsp_valid_q;
	fut_pkg::fut_out_t rsp_q;

	logic          fire;
	logic          full;
	logic          do_write;
	logic          do_start;
	logic          do_pop;
	logic          dropped;
	logic          line_d;
	logic [3:0]    pos_d;
	logic [3:0]    pos_inc;
	logic [2:0]    bit_sel;
	logic [CW-1:0] count_d;

	assign fire       = item_valid && (!rsp_valid_q || rsp_ready);
	assign item_ready = !rsp_valid_q || rsp_ready;
	assign full       = (count_q == CW'(FIFO_DEPTH));
	assign pos_inc    = pos_q + 4'd1;
	assign bit_sel    = 3'(pos_q - 4'd1);

	always_comb begin
		do_write = 1'b0;
		do_start = 1'b0;
		do_pop   = 1'b0;
		dropped  = 1'b0;
		line_d   = line_q;
		pos_d    = pos_q;
		count_d  = count_q;
		if (fire) begin
			if (!item.is_tick) begin
				if (full) begin
					dropped = 1'b1;
				end else begin
					do_write = 1'b1;
					count_d  = count_q + CW'(1);
				end
			end else if (count_q != '0) begin
				if (pos_q == fut_pkg::POS_START) begin
					line_d   = 1'b0;
					do_start = 1'b1;
				end else if (pos_q <= fut_pkg::POS_LAST_DATA) begin
					line_d = send_q[bit_sel];
				end else if (pos_q <= fut_pkg::POS_LAST_STOP) begin
					line_d = 1'b1;
				end
				if (pos_inc >= 4'(FRAME_TICKS)) begin
					pos_d   = fut_pkg::POS_START;
					do_pop  = 1'b1;
					count_d = count_q - CW'(1);
				end else begin
					pos_d = pos_inc;
				end
			end
		end
	end

	// Latch the head byte on the start tick; it drives the data bits after.
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[tail_q] <= item.data;
		end
		if (do_start) begin
			send_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.tx_line       <= line_d;
			rsp_q.fifo_count    <= fut_pkg::COUNT_W'(count_d);
			rsp_q.write_dropped <= dropped;
			rsp_q.frame_done    <= do_pop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			pos_q       <= fut_pkg::POS_START;
			line_q      <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (do_write) begin
				tail_q <= (tail_q == AW'(FIFO_DEPTH - 1)) ? '0 : tail_q + AW'(1);
			end
			if (do_pop) begin
				head_q <= (head_q == AW'(FIFO_DEPTH - 1)) ? '0 : head_q + AW'(1);
			end
			count_q <= count_d;
			pos_q   <= pos_d;
			line_q  <= line_d;
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`FUT_ASSERT(a_count_bound, count_q <= CW'(FIFO_DEPTH), "byte count above depth")
	`FUT_ASSERT(a_frame_needs_byte, (pos_q == fut_pkg::POS_START) || (count_q != '0), "frame in progress with empty fifo")
	`FUT_ASSERT(a_drop_when_full, !(rsp_valid_q && rsp_q.write_dropped) || full, "drop reported while fifo not full")
	`FUT_ASSERT_NEXT(a_done_resets_pos, do_pop, pos_q == fut_pkg::POS_START && rsp_q.frame_done, "pop did not restart frame")

endmodule

// ===== sv/fifo_uart_transmitter.sv =====
// Channel  Direction  Type       Handshake
// req      in         fut_in_t   req_valid / req_ready
// rsp      out        fut_out_t  rsp_valid / rsp_ready
//
// One beat in, one beat out; one beat per cycle sustained while rsp is not stalled, via the queue and rsp register.
// The rate is set by the two-entry item queue feeding a sequencer that takes an item whenever its rsp beat is free.
// arst_n clears pointers, count, frame position and rsp_valid, and sets the line high.
// A stalled rsp beat holds the sequencer; req keeps flowing until the queue fills.
module fifo_uart_transmitter #(
	parameter int FIFO_DEPTH  = fut_pkg::FIFO_DEPTH_DEF,
	parameter int FRAME_TICKS = fut_pkg::FRAME_TICKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  fut_pkg::fut_in_t  req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output fut_pkg::fut_out_t rsp
);

	logic               item_valid;
	logic               item_ready;
	fut_pkg::fut_item_t item;

	fut_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	fut_back #(
		.FIFO_DEPTH  (FIFO_DEPTH),
		.FRAME_TICKS (FRAME_TICKS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int DEPTH        = fut_pkg::FIFO_DEPTH_DEF;
	localparam int TICKS        = fut_pkg::FRAME_TICKS_DEF;
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_LIMIT   = 4000;
	localparam int TAIL_CYCLES  = 8;

	// Byte FIFO and frame sequencer predictor plus the queue of expected beats.
	class tx_scoreboard;
		logic [7:0]        held_bytes[$];
		logic [3:0]        frame_pos;
		logic [7:0]        shift_byte;
		logic              line_q;
		fut_pkg::fut_out_t expected_beats[$];

		function new();
			frame_pos  = fut_pkg::POS_START;
			shift_byte = 8'h15;
			line_q     = 1'b1;
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		function void note_request(fut_pkg::fut_in_t item);
			fut_pkg::fut_out_t want;
			want = '0;
			if (item.req_type == fut_pkg::REQ_PUSH) begin
				if (held_bytes.size() >= DEPTH)
					want.write_dropped = 1'b1;
				else
					held_bytes.push_back(item.data_byte);
			end else if (held_bytes.size() != 0) begin
				// latch the head byte on the start bit
				if (frame_pos == fut_pkg::POS_START) begin
					line_q     = 1'b0;
					shift_byte = held_bytes[0];
				end else if (frame_pos <= fut_pkg::POS_LAST_DATA) begin
					line_q = shift_byte[int'(frame_pos) - 1];
				end else if (frame_pos <= fut_pkg::POS_LAST_STOP) begin
					line_q = 1'b1;
				end
				frame_pos = frame_pos + 4'd1;
				if (int'(frame_pos) >= TICKS) begin
					frame_pos = fut_pkg::POS_START;
					void'(held_bytes.pop_front());
					want.frame_done = 1'b1;
				end
			end
			want.tx_line    = line_q;
			want.fifo_count = fut_pkg::COUNT_W'(held_bytes.size());
			expected_beats.push_back(want);
		endfunction

		function string check_response(fut_pkg::fut_out_t got);
			fut_pkg::fut_out_t want;
			string             msg;
			msg = "";
			if (expected_beats.size() == 0)
				return $sformatf("rsp beat %h with nothing expected", got);
			want = expected_beats.pop_front();
			if (got.tx_line !== want.tx_line)
				msg = {msg, $sformatf(" tx_line %b/%b", got.tx_line, want.tx_line)};
			if (got.fifo_count !== want.fifo_count)
				msg = {msg, $sformatf(" fifo_count %0d/%0d", got.fifo_count,
					want.fifo_count)};
			if (got.write_dropped !== want.write_dropped)
				msg = {msg, $sformatf(" write_dropped %b/%b", got.write_dropped,
					want.write_dropped)};
			if (got.frame_done !== want.frame_done)
				msg = {msg, $sformatf(" frame_done %b/%b", got.frame_done,
					want.frame_done)};
			return msg;
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              req_valid;
	logic              req_ready;
	fut_pkg::fut_in_t  req;
	logic              rsp_valid;
	logic              rsp_ready;
	fut_pkg::fut_out_t rsp;

	tx_scoreboard sb;
	int  errors;
	int  rsp_count;
	int  idle_cycles;
	bit  no_idle;
	bit  hold_rsp;

	fifo_uart_transmitter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= 200)
			$display("MISMATCH beat %0d:%s", rsp_count, what);
	endtask

	task automatic send_item(input fut_pkg::fut_in_t item);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
		sb.note_request(item);
	endtask

	task automatic send_push(input logic [7:0] value);
		fut_pkg::fut_in_t item;
		item.req_type  = fut_pkg::REQ_PUSH;
		item.data_byte = value;
		send_item(item);
	endtask

	task automatic send_tick();
		fut_pkg::fut_in_t item;
		item.req_type  = fut_pkg::REQ_TICK;
		item.data_byte = 8'($urandom);
		send_item(item);
	endtask

	// Random bursts of pushes or ticks; tick_pct picks each burst's kind, and its length is random.
	task automatic run_bursts(input int n_items, input int tick_pct, input int max_push,
		input int max_tick);
		int sent;
		int len;
		bit ticking;
		sent = 0;
		while (sent < n_items) begin
			ticking = ($urandom_range(0, 99) < tick_pct);
			len = ticking ? $urandom_range(1, max_tick) : $urandom_range(1, max_push);
			repeat (len) begin
				if (ticking)
					send_tick();
				else
					send_push(8'($urandom));
			end
			sent += len;
		end
	endtask

	task automatic wait_for_drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Response side: random stalls, and one long hold-off when asked.
	initial begin
		int n;
		bit held;
		held      = 1'b0;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_rsp && !held) begin
				n    = HOLD_CYCLES;
				held = 1'b1;
			end else begin
				n = no_idle ? 0 : $urandom_range(0, 12);
			end
			if (n > 0) begin
				rsp_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			begin
				string msg;
				msg = sb.check_response(rsp);
				if (msg != "")
					report_mismatch(msg);
			end
			rsp_count++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		errors    = 0;
		rsp_count = 0;
		no_idle   = 1'b0;
		hold_rsp  = 1'b0;
		sb        = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ticks on an empty FIFO leave the line high
		send_tick();
		send_tick();
		// one whole frame of zeros
		send_push(8'h00);
		repeat (TICKS) send_tick();
		// push after the start bit; the frame keeps the latched byte
		send_push(8'hFF);
		send_tick();
		send_push(8'hA5);
		send_tick();
		send_tick();

		run_bursts(300, 60, 3, 20);
		wait_for_drain();

		// fill past full with no idling while the response side holds off
		no_idle  = 1'b1;
		hold_rsp = 1'b1;
		run_bursts(620, 5, 30, 2);
		no_idle  = 1'b0;

		run_bursts(230, 70, 4, 16);
		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.pending() != 0)
			report_mismatch($sformatf(" %0d beats never arrived", sb.pending()));
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
